@@ hdl/skvt_pkg.sv @@
// Shared types and codes for the sorted key/value table.
package skvt_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int ACT_W   = 2;
  localparam int CNT_OUT_W = 5;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  // Status codes
  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic                    present;
    logic signed [VAL_W-1:0] old_value;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic                    status;
  } out_t;

  // One stored entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  // Update command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert a new key, shift later entries right
    logic rem;  // remove the hit, shift later entries left
    logic rep;  // replace the value of the hit
  } cell_cmd_t;

endpackage

@@ hdl/sorted_key_value_table.sv @@
// Sorted key/value table built as a chain of shifting cells.
//
// Holds up to TABLE_DEPTH unique signed keys with values, packed in sorted
// order (ascending, or descending when cfg_wdata wrote 1). Each input beat adds
// or replaces, searches, or removes one key and yields one output beat with
// present, old value, new entry count and a full flag. An item passes through a
// compare state, in which every cell compares its key to the item key and
// registers its flags, and an update state, in which the flag chain picks the
// insert or remove point and all cells shift at once. The update waits while
// the output still holds a result that out_ready has not taken. The next item
// is taken in the update state, so a new item overlaps the last one's update;
// the result is registered at the update. Write cfg_ only while no item is in flight.
module sorted_key_value_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           in_valid,
  output logic           in_ready,
  input  skvt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output skvt_pkg::out_t out_data
);
  import skvt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic          desc_r;
  in_t           item_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  out_t          out_data_r, res;
  logic          out_free, upd_go, in_acc, found, full;
  cell_cmd_t     cmd;
  slot_t         item_slot;
  logic [VAL_W-1:0] hit_or;

  slot_t               slot_w  [TABLE_DEPTH];
  logic [VAL_W-1:0]    hitv_w  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_vec;
  logic [TABLE_DEPTH:0]   seen_c, hit_c;

  // Handshake and sequencing
  assign out_free = ~out_valid_r | out_ready;
  assign upd_go   = (state_r == S_UPD) && out_free;
  assign in_ready = (state_r == S_IDLE) || upd_go;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   if (out_free) state_nxt = in_valid ? S_CMP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      desc_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) desc_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) item_r <= in_data;
  end

  assign item_slot = '{key: item_r.key, value: item_r.value};

  // Cell chain
  assign seen_c[0] = 1'b0;
  assign hit_c[0]  = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    slot_t left_s, right_s;
    logic  left_v, right_v;
    if (i == 0) begin : g_first
      assign left_s = '0;
      assign left_v = 1'b0;
    end else begin : g_mid_l
      assign left_s = slot_w[i-1];
      assign left_v = valid_vec[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_s = '0;
      assign right_v = 1'b0;
    end else begin : g_mid_r
      assign right_s = slot_w[i+1];
      assign right_v = valid_vec[i+1];
    end
    skvt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmp_en     (state_r == S_CMP),
      .desc       (desc_r),
      .item_slot  (item_slot),
      .cmd        (cmd),
      .left_slot  (left_s),
      .left_valid (left_v),
      .right_slot (right_s),
      .right_valid(right_v),
      .seen_in    (seen_c[i]),
      .hit_in     (hit_c[i]),
      .slot       (slot_w[i]),
      .valid      (valid_vec[i]),
      .seen_out   (seen_c[i+1]),
      .hit_out    (hit_c[i+1]),
      .hit_value  (hitv_w[i])
    );
  end

  // Hit value: at most one cell is nonzero
  always_comb begin
    hit_or = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) hit_or = hit_or | hitv_w[i];
  end

  assign found = hit_c[TABLE_DEPTH];
  assign full  = (count_r == FULL_CNT);

  // Update command and result
  always_comb begin
    cmd       = '0;
    count_nxt = count_r;
    res       = '0;
    unique case (item_r.action)
      ACT_ADD: begin
        if (found) begin
          cmd.rep = upd_go;
        end else if (!full) begin
          cmd.ins   = upd_go;
          count_nxt = count_r + CW'(1);
        end else begin
          res.status = ST_FULL;
        end
        res.present   = found;
        res.old_value = hit_or;
      end
      ACT_SEARCH: begin
        res.present   = found;
        res.old_value = hit_or;
      end
      ACT_REMOVE: begin
        if (found) begin
          cmd.rem   = upd_go;
          count_nxt = count_r - CW'(1);
        end
        res.present   = found;
        res.old_value = hit_or;
      end
      default: ;
    endcase
    res.entry_count = CNT_OUT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (upd_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // Live cells match the entry count
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == count_r)
    else $error("valid cells disagree with entry count");

  // Live cells stay packed at the low end of the chain
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + TABLE_DEPTH'(1)) & valid_vec) == '0)
    else $error("live cells not contiguous");

  // A result only follows an update cycle
  a_out_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD))
    else $error("result without update");

  // No item taken during the compare cycle
  a_no_acc_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> !in_ready)
    else $error("input taken during compare");

  // In the update state the hit chain rises at most once along the cells
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $onehot0(hit_c[TABLE_DEPTH:1] ^ hit_c[TABLE_DEPTH-1:0]))
    else $error("more than one cell matched");
`endif

endmodule

@@ hdl/skvt_cell.sv @@
// One table cell: holds an entry, compares it to the item key, shifts with neighbors.
module skvt_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cmp_en,
  input  logic                    desc,
  input  skvt_pkg::slot_t         item_slot,
  input  skvt_pkg::cell_cmd_t     cmd,
  input  skvt_pkg::slot_t         left_slot,
  input  logic                    left_valid,
  input  skvt_pkg::slot_t         right_slot,
  input  logic                    right_valid,
  input  logic                    seen_in,
  input  logic                    hit_in,
  output skvt_pkg::slot_t         slot,
  output logic                    valid,
  output logic                    seen_out,
  output logic                    hit_out,
  output logic [skvt_pkg::VAL_W-1:0] hit_value
);
  import skvt_pkg::*;

  slot_t            slot_r, slot_nxt;
  logic             valid_r, valid_nxt;
  logic             match_r, bef_r;
  logic [VAL_W-1:0] hitv_r;
  logic             match, bef, less_new, less_old, ins_here;

  // Compare against the item key
  always_comb begin
    match    = valid_r && (slot_r.key == item_slot.key);
    less_new = $signed(item_slot.key) < $signed(slot_r.key);
    less_old = $signed(slot_r.key) < $signed(item_slot.key);
    bef      = valid_r && (desc ? less_old : less_new);
  end

  // Compare flags, taken in the compare cycle
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      match_r <= match;
      bef_r   <= bef;
      hitv_r  <= match ? slot_r.value : '0;
    end
  end

  // Chain: insert point is the first live slot the key precedes, else the first free slot
  assign seen_out = seen_in | bef_r | ~valid_r;
  assign ins_here = ~seen_in & (bef_r | ~valid_r);
  assign hit_out  = hit_in | match_r;

  // Entry update; the command bits never overlap, and no command holds the entry
  always_comb begin
    slot_nxt  = slot_r;
    valid_nxt = valid_r;
    if (cmd.ins) begin
      if (ins_here) begin
        slot_nxt  = item_slot;
        valid_nxt = 1'b1;
      end else if (seen_in) begin
        slot_nxt  = left_slot;
        valid_nxt = left_valid;
      end
    end else if (cmd.rem) begin
      if (hit_in | match_r) begin
        slot_nxt  = right_slot;
        valid_nxt = right_valid;
      end
    end else if (cmd.rep) begin
      if (match_r) slot_nxt.value = item_slot.value;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign slot      = slot_r;
  assign valid     = valid_r;
  assign hit_value = hitv_r;

endmodule

@@ sim/sorted_key_value_table_tb.sv @@
// Self-checking testbench for the sorted key/value table: random stimulus and a scoreboard.
module sorted_key_value_table_tb;
  import skvt_pkg::*;

  localparam int DEPTH       = 16;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 150;
  localparam int POOL_SIZE   = 20;
  // Unused action code; the block must leave the table alone
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  sorted_key_value_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Local copy of the table contents
  logic signed [KEY_W-1:0] tbl_keys [DEPTH];
  logic signed [VAL_W-1:0] tbl_vals [DEPTH];
  int   tbl_count = 0;
  logic tbl_descending = 1'b0;

  in_t  pending_items [$];
  out_t expected_results [$];
  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

  int err_count = 0;
  int results_seen = 0;
  int send_gap = 0;
  int send_burst = 0;
  int hold_left = 0;
  int ready_mode = 0;
  bit held_long = 1'b0;
  int quiet_cycles = 0;

  // Apply one beat to the local table and return the result it should produce
  function automatic out_t apply_to_table(in_t beat);
    out_t res;
    int   hit;
    int   pos;
    res = '0;
    res.status = ST_DONE;
    hit = -1;
    pos = tbl_count;
    for (int i = 0; i < tbl_count; i++) begin
      if (hit < 0 && tbl_keys[i] == beat.key) hit = i;
    end
    case (beat.action)
      ACT_ADD: begin
        if (hit >= 0) begin
          res.present = 1'b1;
          res.old_value = tbl_vals[hit];
          tbl_vals[hit] = beat.value;
        end else if (tbl_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // first live slot the new key goes in front of, under the current order
          for (int i = 0; i < tbl_count; i++) begin
            if (pos == tbl_count &&
                (tbl_descending ? (tbl_keys[i] < beat.key) : (beat.key < tbl_keys[i])))
              pos = i;
          end
          for (int i = tbl_count; i > pos; i--) begin
            tbl_keys[i] = tbl_keys[i-1];
            tbl_vals[i] = tbl_vals[i-1];
          end
          tbl_keys[pos] = beat.key;
          tbl_vals[pos] = beat.value;
          tbl_count++;
        end
      end
      ACT_SEARCH: begin
        if (hit >= 0) begin
          res.present = 1'b1;
          res.old_value = tbl_vals[hit];
        end
      end
      ACT_REMOVE: begin
        if (hit >= 0) begin
          res.present = 1'b1;
          res.old_value = tbl_vals[hit];
          for (int i = hit; i + 1 < tbl_count; i++) begin
            tbl_keys[i] = tbl_keys[i+1];
            tbl_vals[i] = tbl_vals[i+1];
          end
          tbl_count--;
        end
      end
      default: ;
    endcase
    res.entry_count = CNT_OUT_W'(tbl_count);
    return res;
  endfunction

  task automatic queue_item(logic [ACT_W-1:0] act, logic signed [KEY_W-1:0] k,
                            logic signed [VAL_W-1:0] v);
    in_t beat;
    beat.action = act;
    beat.key = k;
    beat.value = v;
    pending_items.push_back(beat);
  endtask

  // Mostly keys from a small pool so hits, replaces and a full table are common
  task automatic queue_random(int n, int add_pct, int rem_pct);
    in_t beat;
    int  pick;
    for (int k = POOL_SIZE / 2; k < POOL_SIZE; k++) begin
      if ($urandom_range(0, 1)) key_pool[k] = $urandom;
      else key_pool[k] = int'($urandom_range(0, 40)) - 20;
    end
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < add_pct) beat.action = ACT_ADD;
      else if (pick < add_pct + rem_pct) beat.action = ACT_REMOVE;
      else if (pick < 92) beat.action = ACT_SEARCH;
      else beat.action = ACT_NOP;
      if ($urandom_range(0, 99) < 85) beat.key = key_pool[$urandom_range(0, POOL_SIZE-1)];
      else beat.key = $urandom;
      pick = $urandom_range(0, 19);
      if (pick == 0) beat.value = KEY_MIN;
      else if (pick == 1) beat.value = KEY_MAX;
      else beat.value = $urandom;
      pending_items.push_back(beat);
    end
  endtask

  // Wait until every queued beat is sent and every result has come back
  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_order(logic desc);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= desc;
    tbl_descending = desc;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Driver: sends pending beats with random gaps and gap-free bursts
  always @(posedge clk) begin : driver
    in_t beat;
    int  pick;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        beat = pending_items.pop_front();
        expected_results.push_back(apply_to_table(beat));
        if (send_burst > 0) begin
          send_burst--;
          send_gap = 0;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 3) begin
            send_burst = $urandom_range(10, 40);
            send_gap = 0;
          end else if (pick < 50) send_gap = 0;
          else if (pick < 85) send_gap = $urandom_range(1, 3);
          else if (pick < 97) send_gap = $urandom_range(4, 12);
          else send_gap = $urandom_range(20, 50);
        end
      end
      if (in_valid && !in_ready) begin
        // hold the beat until it is taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result beat and drives out_ready with random stalls
  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.present !== want.present) begin
            $error("present: expected %0d, got %0d", want.present, out_data.present);
            err_count++;
          end
          if (out_data.old_value !== want.old_value) begin
            $error("old_value: expected %0d, got %0d", want.old_value, out_data.old_value);
            err_count++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_data.entry_count);
            err_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            err_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= 400 && !held_long) begin
        // one long back-pressure stretch so the input side backs up
        held_long = 1'b1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) < 2) ready_mode = $urandom_range(0, 2);
        if ($urandom_range(0, 199) == 0) begin
          hold_left = $urandom_range(15, 40);
          out_ready <= 1'b0;
        end else begin
          case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 99) >= 25);
            default: out_ready <= ($urandom_range(0, 99) >= 60);
          endcase
        end
      end
    end
  end

  // Watchdog: ends the run if no beat moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("FAIL sorted_key_value_table");
          $finish;
        end
      end
    end
  end

  initial begin
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 0;
    key_pool[3] = -1;
    key_pool[4] = 1;
    for (int k = 5; k < POOL_SIZE; k++) key_pool[k] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes, replace, fill up, full refusal
    write_order(1'b0);
    queue_item(ACT_SEARCH, 5, 7);
    queue_item(ACT_REMOVE, KEY_MIN, 0);
    queue_item(ACT_NOP, 0, 3);
    queue_item(ACT_ADD, KEY_MIN, KEY_MAX);
    queue_item(ACT_ADD, KEY_MAX, KEY_MIN);
    queue_item(ACT_ADD, 0, 0);
    queue_item(ACT_ADD, -1, 1);
    queue_item(ACT_ADD, 1, -1);
    queue_item(ACT_ADD, 0, 32'sh5a5a_5a5a);
    queue_item(ACT_SEARCH, KEY_MAX, 0);
    queue_item(ACT_REMOVE, -1, 0);
    for (int k = 0; k < DEPTH - 4; k++) queue_item(ACT_ADD, k * 1000 - 5993, $urandom);
    queue_item(ACT_ADD, 12345, 99);
    queue_item(ACT_ADD, KEY_MAX, 32'sh0bad_cafe);
    wait_idle();

    // Flip the order with a full table held, then keep changing it
    write_order(1'b1);
    queue_random(250, 40, 30);
    wait_idle();
    write_order(1'b0);
    queue_random(260, 35, 35);
    wait_idle();
    write_order(1'b1);
    queue_random(260, 45, 25);
    wait_idle();
    write_order(1'b0);
    queue_random(250, 30, 40);
    wait_idle();
    repeat (10) @(posedge clk);

    if (err_count == 0 && expected_results.size() == 0) begin
      $display("PASS sorted_key_value_table");
    end else begin
      $display("FAIL sorted_key_value_table");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/skvt_pkg.sv
hdl/skvt_cell.sv
hdl/sorted_key_value_table.sv
sim/sorted_key_value_table_tb.sv
